>>> design/quote_aware_statement_splitter_macros.svh
// ---------------------------------------------------------------------------
// quote_aware_statement_splitter_macros.svh
// Assertion macros for the statement splitter; empty when synthesized.
// ---------------------------------------------------------------------------
`ifndef QUOTE_AWARE_STATEMENT_SPLITTER_MACROS_SVH
`define QUOTE_AWARE_STATEMENT_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
// Check under clock, skipped while reset is asserted.
`define QSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check under clock at every edge, reset included.
`define QSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSS_ASSERT(label, clk, rst_n, prop, msg)
`define QSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> design/qss_pkg.sv
// ---------------------------------------------------------------------------
// qss_pkg
// Shared types, character constants and the prefix table of the splitter.
// ---------------------------------------------------------------------------
package qss_pkg;

    typedef enum logic [1:0] {
        QUOTE_NONE     = 2'd0,
        QUOTE_SINGLE   = 2'd1,
        QUOTE_DOUBLE   = 2'd2,
        QUOTE_BACKTICK = 2'd3
    } quote_t;

    localparam logic [7:0] CHAR_SEMI      = 8'h3B;
    localparam logic [7:0] CHAR_BSLASH    = 8'h5C;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    localparam logic [3:0] PREFIX_LEN = 4'd11;

    // One result beat as it leaves the scanner.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       stmt_end;
        logic       bulk;
    } scan_result_t;

    // "INSERT INTO", one character per position.
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h49; // I
            4'd1:    c = 8'h4E; // N
            4'd2:    c = 8'h53; // S
            4'd3:    c = 8'h45; // E
            4'd4:    c = 8'h52; // R
            4'd5:    c = 8'h54; // T
            4'd6:    c = 8'h20; // space
            4'd7:    c = 8'h49; // I
            4'd8:    c = 8'h4E; // N
            4'd9:    c = 8'h54; // T
            4'd10:   c = 8'h4F; // O
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic quote_t quote_code(input logic [7:0] b);
        quote_t q;
        case (b)
            CHAR_SQUOTE:   q = QUOTE_SINGLE;
            CHAR_DQUOTE:   q = QUOTE_DOUBLE;
            CHAR_BACKTICK: q = QUOTE_BACKTICK;
            default:       q = QUOTE_NONE;
        endcase
        return q;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

endpackage

>>> design/qss_in_stage.sv
// ---------------------------------------------------------------------------
// qss_in_stage
// Input register: holds one byte beat until the scanner moves it on.
// ---------------------------------------------------------------------------
module qss_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
endmodule

>>> design/qss_scanner.sv
// ---------------------------------------------------------------------------
// qss_scanner
// Quote, escape and prefix tracking; decides each byte's result.
// ---------------------------------------------------------------------------
module qss_scanner (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data,
    input  logic                 advance,
    output qss_pkg::scan_result_t result
);
    import qss_pkg::*;

    logic       at_start_reg;
    logic       at_start_next;
    quote_t     quote_reg;
    quote_t     quote_next;
    logic       esc_reg;
    logic       esc_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       match_reg;
    logic       match_next;
    logic       drop;

    always_comb
    begin
        at_start_next   = at_start_reg;
        quote_next      = quote_reg;
        esc_next        = esc_reg;
        pos_next        = pos_reg;
        match_next      = match_reg;
        drop            = at_start_reg && is_blank(data);
        result.emit     = !drop;
        result.data     = data;
        result.stmt_end = 1'b0;
        result.bulk     = 1'b0;

        if (!drop)
        begin
            at_start_next = 1'b0;
            if (pos_reg < PREFIX_LEN)
            begin
                if (data != prefix_char(pos_reg))
                begin
                    match_next = 1'b0;
                end
                pos_next = pos_reg + 4'd1;
            end

            if (quote_reg == QUOTE_NONE)
            begin
                if (data == CHAR_SEMI)
                begin
                    // Close the statement and rearm for the next one.
                    result.stmt_end = 1'b1;
                    result.bulk     = match_next && (pos_next == PREFIX_LEN);
                    at_start_next   = 1'b1;
                    pos_next        = 4'd0;
                    match_next      = 1'b1;
                    esc_next        = 1'b0;
                end
                else
                begin
                    quote_next = quote_code(data);
                end
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if (data == CHAR_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (quote_code(data) == quote_reg)
            begin
                quote_next = QUOTE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            quote_reg    <= QUOTE_NONE;
            esc_reg      <= 1'b0;
            pos_reg      <= 4'd0;
            match_reg    <= 1'b1;
        end
        else if (advance)
        begin
            at_start_reg <= at_start_next;
            quote_reg    <= quote_next;
            esc_reg      <= esc_next;
            pos_reg      <= pos_next;
            match_reg    <= match_next;
        end
    end
endmodule

>>> design/qss_out_stage.sv
// ---------------------------------------------------------------------------
// qss_out_stage
// Result register: holds one result beat until the sink takes it.
// ---------------------------------------------------------------------------
module qss_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  qss_pkg::scan_result_t result,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 statement_end,
    output logic                 is_bulk_insert
);
    import qss_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       bulk_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= result.data;
            end_reg  <= result.stmt_end;
            bulk_reg <= result.bulk;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign statement_end  = end_reg;
    assign is_bulk_insert = bulk_reg;
endmodule

>>> design/quote_aware_statement_splitter.sv
// ---------------------------------------------------------------------------
// quote_aware_statement_splitter
// Splits a byte stream into statements, skipping leading blanks and
// flagging statements that open with INSERT INTO.
// ---------------------------------------------------------------------------
//  channel | signals                                        | beat
//  --------+------------------------------------------------+-----------------
//  in      | in_valid, in_ready, in_byte                    | one script byte
//  out     | out_valid, out_ready, out_byte, statement_end, | one passed byte
//          | is_bulk_insert                                 |
//
// One byte per cycle sustained while the output is not stalled; a byte taken
// at the input passes the input register, then the result register.
// Leading blanks of a statement are absorbed and give no output beat.
// Reset (rst_n low) empties both registers and rearms the statement scan.
// A stalled output holds its beat; the input register keeps taking bytes
// as long as a blank is dropped or the result register frees up.
module quote_aware_statement_splitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       statement_end,
    output logic       is_bulk_insert
);
    import qss_pkg::*;
`include "quote_aware_statement_splitter_macros.svh"

    logic         hold_valid;
    logic [7:0]   hold_byte;
    logic         advance;
    logic         space;
    logic         load;
    scan_result_t result;

    // Move the held byte on when it is dropped or the result slot is free.
    assign advance = hold_valid && (!result.emit || space);
    assign load    = advance && result.emit;

    qss_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    qss_scanner u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .data    (hold_byte),
        .advance (advance),
        .result  (result)
    );

    qss_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .result         (result),
        .space          (space),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .statement_end  (statement_end),
        .is_bulk_insert (is_bulk_insert)
    );

    `QSS_ASSERT(a_end_is_semi, clk, rst_n, out_valid && statement_end |-> out_byte == CHAR_SEMI, "statement end on a byte other than a semicolon")
    `QSS_ASSERT(a_bulk_needs_end, clk, rst_n, out_valid && is_bulk_insert |-> statement_end, "bulk flag without statement end")
    `QSS_ASSERT(a_hold_stable, clk, rst_n, hold_valid && !advance |=> hold_valid && $stable(hold_byte), "held input byte lost while stalled")
    `QSS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid && !hold_valid, "registers not empty in reset")
endmodule

>>> tb/tb_quote_aware_statement_splitter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quote_aware_statement_splitter
// Sends scripts byte by byte with random gaps on both channels, predicts
// every passed byte with its end and INSERT INTO flags, and checks each beat.
// ---------------------------------------------------------------------------
module tb_quote_aware_statement_splitter;
    import qss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 600;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [8*11-1:0] BULK_TEXT = "INSERT INTO";

    typedef struct packed {
        logic [7:0] data;
        logic       stmt_end;
        logic       bulk;
    } passed_beat_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       statement_end;
    logic       is_bulk_insert;

    // scanner state as predicted
    logic       at_start;
    quote_t     open_q;
    logic       esc_pending;
    logic [3:0] prefix_pos;
    logic       prefix_ok;

    passed_beat_t expected_beats_q[$];
    passed_beat_t want;

    bit          gaps_on = 1'b1;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_bytes = 0;
    int unsigned checked_beats = 0;
    int unsigned statements = 0;
    int unsigned bulk_statements = 0;

    quote_aware_statement_splitter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .statement_end  (statement_end),
        .is_bulk_insert (is_bulk_insert)
    );

    always #5 clk = ~clk;

    function automatic logic blank_byte(input logic [7:0] b);
        case (b)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
            default:                                 return 1'b0;
        endcase
    endfunction

    // Advance the predicted scanner by one accepted byte.
    function automatic void scan_byte(input logic [7:0] b);
        passed_beat_t beat;
        quote_t       q;
        if (at_start && blank_byte(b))
            return;
        at_start = 1'b0;
        if (b == CHAR_SQUOTE)
            q = QUOTE_SINGLE;
        else if (b == CHAR_DQUOTE)
            q = QUOTE_DOUBLE;
        else if (b == CHAR_BACKTICK)
            q = QUOTE_BACKTICK;
        else
            q = QUOTE_NONE;
        beat.data     = b;
        beat.stmt_end = 1'b0;
        beat.bulk     = 1'b0;
        if (prefix_pos < PREFIX_LEN)
        begin
            if (b != BULK_TEXT[8*(PREFIX_LEN-1-prefix_pos) +: 8])
                prefix_ok = 1'b0;
            prefix_pos = prefix_pos + 4'd1;
        end
        if (open_q == QUOTE_NONE)
        begin
            if (b == CHAR_SEMI)
            begin
                beat.stmt_end = 1'b1;
                beat.bulk     = prefix_ok && (prefix_pos == PREFIX_LEN);
                at_start      = 1'b1;
                prefix_pos    = 4'd0;
                prefix_ok     = 1'b1;
                esc_pending   = 1'b0;
                statements++;
                if (beat.bulk)
                    bulk_statements++;
            end
            else
                open_q = q;
        end
        else if (esc_pending)
            esc_pending = 1'b0;
        else if (b == CHAR_BSLASH)
            esc_pending = 1'b1;
        else if (q == open_q)
            open_q = QUOTE_NONE;
        expected_beats_q = {expected_beats_q, beat};
    endfunction

    function automatic logic [7:0] random_blank();
        int unsigned r;
        r = $urandom_range(5);
        return (r == 5) ? CHAR_SPACE : 8'h09 + r[7:0];
    endfunction

    function automatic logic [7:0] random_body_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)       return CHAR_SQUOTE;
        else if (r < 14) return CHAR_DQUOTE;
        else if (r < 20) return CHAR_BACKTICK;
        else if (r < 28) return CHAR_BSLASH;
        else if (r < 34) return CHAR_SEMI;
        else if (r < 40) return random_blank();
        else if (r < 44) return 8'h00;
        else if (r < 48) return 8'hFF;
        else             return 8'($urandom_range(255));
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] exp_v);
        errors++;
        if (errors <= 100)
            $display("mismatch on %s at beat %0d: got %h, want %h",
                     field, checked_beats, got, exp_v);
    endtask

    // Call at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scan_byte(b);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Close any open string, then end the statement.
    task automatic close_statement();
        if (open_q != QUOTE_NONE)
        begin
            if (esc_pending)
                send_byte("a");
            case (open_q)
                QUOTE_SINGLE:   send_byte(CHAR_SQUOTE);
                QUOTE_DOUBLE:   send_byte(CHAR_DQUOTE);
                default:        send_byte(CHAR_BACKTICK);
            endcase
        end
        send_byte(CHAR_SEMI);
    endtask

    task automatic send_random_statement();
        int unsigned kind;
        int unsigned k;
        int unsigned flip_at;
        logic [7:0]  b;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(20, 1))
                send_byte(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(3))
            send_byte(random_blank());
        if (kind < 55)
        begin
            // intact prefix, one flipped bit, or cut short
            k       = (kind < 45) ? PREFIX_LEN : $urandom_range(PREFIX_LEN - 1, 1);
            flip_at = $urandom_range(PREFIX_LEN - 1);
            for (int i = 0; i < k; i++)
            begin
                b = BULK_TEXT[8*(10-i) +: 8];
                if (kind >= 35 && kind < 45 && i == flip_at)
                    b = b ^ (8'h01 << $urandom_range(7));
                send_byte(b);
            end
        end
        repeat ($urandom_range(12))
            send_byte(random_body_byte());
        if ($urandom_range(9) != 0)
            close_statement();
    endtask

    task automatic test_blank_skip();
        send_byte(CHAR_SPACE);
        send_byte(CHAR_TAB);
        send_byte(8'h0A);
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(CHAR_CR);
        send_byte(8'h08);
        send_byte(CHAR_SPACE);
        send_byte(CHAR_SEMI);
    endtask

    task automatic test_bulk_prefix();
        send_text("INSERT INTO;");
        send_text("INSERT;");
    endtask

    task automatic test_quoting();
        send_text("'\\';';");
        send_text("\"'\";");
    endtask

    task automatic test_edge_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CHAR_SEMI);
    endtask

    task automatic test_random_script();
        int unsigned start_count;
        start_count = sent_bytes;
        while (sent_bytes - start_count < RANDOM_BYTES)
        begin
            // hold a long stretch with no gaps on either side
            gaps_on = !((sent_bytes - start_count) inside {[200:350]});
            send_random_statement();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_unterminated_tail();
        if (!at_start)
            close_statement();
        send_text("INSERT INTO x");
        in_valid = 1'b0;
    endtask

    always @(negedge clk)
        out_ready = !gaps_on || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats_q.size() == 0)
                report_mismatch("unexpected beat", out_byte, 8'h00);
            else
            begin
                want = expected_beats_q[0];
                expected_beats_q.delete(0);
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (statement_end !== want.stmt_end)
                    report_mismatch("statement_end", {7'd0, statement_end},
                                    {7'd0, want.stmt_end});
                if (is_bulk_insert !== want.bulk)
                    report_mismatch("is_bulk_insert", {7'd0, is_bulk_insert},
                                    {7'd0, want.bulk});
            end
            checked_beats++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, expected_beats_q.size());
            $display("** quote_aware_statement_splitter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        at_start    = 1'b1;
        open_q      = QUOTE_NONE;
        esc_pending = 1'b0;
        prefix_pos  = 4'd0;
        prefix_ok   = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_blank_skip();
        test_bulk_prefix();
        test_quoting();
        test_edge_bytes();
        test_random_script();
        test_unterminated_tail();

        while (expected_beats_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d beats in %0d cycles",
                 sent_bytes, checked_beats, cycle_count);
        $display("statements ended: %0d, flagged INSERT INTO: %0d, mismatches: %0d",
                 statements, bulk_statements, errors);
        if (errors == 0)
            $display("** quote_aware_statement_splitter: PASSED **");
        else
            $display("** quote_aware_statement_splitter: FAILED **");
        $finish;
    end

endmodule
